### hdl/rth_pkg.sv
package rth_pkg;

  localparam int unsigned CHAN_W     = 8;
  localparam int unsigned SUM_W      = CHAN_W + 1;
  localparam int unsigned REM_W      = 17;
  localparam int unsigned Q_W        = 8;
  localparam int unsigned DIV_STAGES = 4;
  localparam int unsigned BITS_PER_STAGE = Q_W / DIV_STAGES;
  localparam int unsigned NUM_DIVS   = 4;

  localparam logic [CHAN_W-1:0] HLS_SCALE      = 8'd255;
  localparam logic [CHAN_W-1:0] HUE_GREY       = 8'd170;
  localparam logic [CHAN_W-1:0] HUE_SIXTH      = 8'd42;
  localparam logic [CHAN_W-1:0] HUE_THIRD      = 8'd85;
  localparam logic [CHAN_W-1:0] HUE_TWO_THIRDS = 8'd170;
  localparam logic [CHAN_W-1:0] LUM_HALF       = 8'd127;
  localparam logic [SUM_W-1:0]  SUM_FULL       = 9'd510;

  // divider lanes
  localparam int unsigned DIV_SAT = 0;
  localparam int unsigned DIV_RD  = 1;
  localparam int unsigned DIV_GD  = 2;
  localparam int unsigned DIV_BD  = 3;

  typedef enum logic [1:0] {
    SEL_RED,
    SEL_GREEN,
    SEL_BLUE
  } sel_t;

  typedef struct packed {
    logic [CHAN_W-1:0] lum;
    logic              grey;
    sel_t              sel;
  } ctl_t;

endpackage

### hdl/rgb_to_hls_pixel_top.sv
// Throughput: one pixel per cycle; a stalled output stops only the stages behind
//   a full stage, so bubbles are squeezed out before in_ready drops.
// Pipeline: min/max, numerator setup, four 2-bit restoring divide stages, hue merge.
// Reset: synchronous active-low rst_n clears all stage valid bits; data regs are not reset.
module rgb_to_hls_pixel_top (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [23:0]                in_packed_rgb,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [rth_pkg::CHAN_W-1:0] out_lightness,
  output logic [rth_pkg::CHAN_W-1:0] out_saturation,
  output logic [rth_pkg::CHAN_W-1:0] out_hue
);
  import rth_pkg::*;

  // ---------------------------------------------------------------------------
  // Handshake: a stage loads when it is empty or its contents move on.
  // Index 0 = stage A, 1 = setup, 2..5 = divide, 6 = output.
  // ---------------------------------------------------------------------------
  localparam int unsigned NSTG = DIV_STAGES + 3;

  logic [NSTG-1:0] v_r;
  logic [NSTG-1:0] adv;

  always_comb begin
    adv[NSTG-1] = !v_r[NSTG-1] || out_ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      adv[k] = !v_r[k] || adv[k+1];
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = v_r[NSTG-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (adv[0]) begin
        v_r[0] <= in_valid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (adv[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage A: unpack, largest and smallest channel.
  // ---------------------------------------------------------------------------
  logic [CHAN_W-1:0] r_r, g_r, b_r, top_r, bot_r;
  logic [CHAN_W-1:0] r_in, g_in, b_in, top_nxt, bot_nxt;

  always_comb begin
    r_in    = in_packed_rgb[7:0];
    g_in    = in_packed_rgb[15:8];
    b_in    = in_packed_rgb[23:16];
    top_nxt = r_in;
    bot_nxt = r_in;
    if (g_in > top_nxt) top_nxt = g_in;
    if (b_in > top_nxt) top_nxt = b_in;
    if (g_in < bot_nxt) bot_nxt = g_in;
    if (b_in < bot_nxt) bot_nxt = b_in;
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      r_r   <= r_in;
      g_r   <= g_in;
      b_r   <= b_in;
      top_r <= top_nxt;
      bot_r <= bot_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Setup stage: lightness, divisors, rounded numerators.
  // (sum*255+255)/510 reduces exactly to (sum+1)/2.
  // Divider data: index 0 is the setup stage, 1..DIV_STAGES the divide stages.
  // ---------------------------------------------------------------------------
  logic [REM_W-1:0] rem_r [0:DIV_STAGES][0:NUM_DIVS-1];
  logic [SUM_W-1:0] den_r [0:DIV_STAGES][0:NUM_DIVS-1];
  logic [Q_W-1:0]   q_r   [0:DIV_STAGES][0:NUM_DIVS-1];
  ctl_t             ctl_r [0:DIV_STAGES];

  logic [SUM_W-1:0] sum_w, spread_w, sat_den_w;
  ctl_t             ctl_nxt;

  always_comb begin
    sum_w       = SUM_W'(top_r) + SUM_W'(bot_r);
    spread_w    = SUM_W'(top_r) - SUM_W'(bot_r);
    ctl_nxt.lum = CHAN_W'((sum_w + SUM_W'(1)) >> 1);
    ctl_nxt.grey = (top_r == bot_r);
    if (r_r == top_r)      ctl_nxt.sel = SEL_RED;
    else if (g_r == top_r) ctl_nxt.sel = SEL_GREEN;
    else                   ctl_nxt.sel = SEL_BLUE;
    sat_den_w = (ctl_nxt.lum <= LUM_HALF) ? sum_w : (SUM_FULL - sum_w);
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      ctl_r[0]          <= ctl_nxt;
      den_r[0][DIV_SAT] <= sat_den_w;
      rem_r[0][DIV_SAT] <= REM_W'(spread_w) * REM_W'(HLS_SCALE) + REM_W'(sat_den_w >> 1);
      den_r[0][DIV_RD]  <= spread_w;
      den_r[0][DIV_GD]  <= spread_w;
      den_r[0][DIV_BD]  <= spread_w;
      rem_r[0][DIV_RD]  <= REM_W'(top_r - r_r) * REM_W'(HUE_SIXTH) + REM_W'(spread_w >> 1);
      rem_r[0][DIV_GD]  <= REM_W'(top_r - g_r) * REM_W'(HUE_SIXTH) + REM_W'(spread_w >> 1);
      rem_r[0][DIV_BD]  <= REM_W'(top_r - b_r) * REM_W'(HUE_SIXTH) + REM_W'(spread_w >> 1);
      for (int j = 0; j < NUM_DIVS; j++) begin
        q_r[0][j] <= '0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Divide stages: restoring division, BITS_PER_STAGE quotient bits each,
  // MSB first. Quotients are known to fit in Q_W bits.
  // ---------------------------------------------------------------------------
  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    logic [REM_W-1:0] rem_nxt [0:NUM_DIVS-1];
    logic [Q_W-1:0]   q_nxt   [0:NUM_DIVS-1];

    always_comb begin
      logic [REM_W-1:0] shd;
      for (int j = 0; j < NUM_DIVS; j++) begin
        rem_nxt[j] = rem_r[k][j];
        q_nxt[j]   = q_r[k][j];
        for (int b = 0; b < BITS_PER_STAGE; b++) begin
          shd = REM_W'(den_r[k][j]) << (Q_W - 1 - k * BITS_PER_STAGE - b);
          if (rem_nxt[j] >= shd) begin
            rem_nxt[j] = rem_nxt[j] - shd;
            q_nxt[j][Q_W-1-k*BITS_PER_STAGE-b] = 1'b1;
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (adv[k+2]) begin
        ctl_r[k+1] <= ctl_r[k];
        for (int j = 0; j < NUM_DIVS; j++) begin
          rem_r[k+1][j] <= rem_nxt[j];
          den_r[k+1][j] <= den_r[k][j];
          q_r[k+1][j]   <= q_nxt[j];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output stage: hue from the deltas of the two non-largest channels,
  // wrapped into 0..255; grey pixels forced to sat 0, hue 170.
  // ---------------------------------------------------------------------------
  localparam int unsigned HUE_W = CHAN_W + 2;

  logic signed [HUE_W-1:0] hue_w;
  logic signed [HUE_W-1:0] rd_s, gd_s, bd_s;
  logic [CHAN_W-1:0]       lum_out_r, sat_out_r, hue_out_r;
  logic [CHAN_W-1:0]       sat_nxt, hue_nxt;
  ctl_t                    ctl_last;

  always_comb begin
    ctl_last = ctl_r[DIV_STAGES];
    rd_s = signed'(HUE_W'(q_r[DIV_STAGES][DIV_RD]));
    gd_s = signed'(HUE_W'(q_r[DIV_STAGES][DIV_GD]));
    bd_s = signed'(HUE_W'(q_r[DIV_STAGES][DIV_BD]));
    unique case (ctl_last.sel)
      SEL_RED:   hue_w = bd_s - gd_s;
      SEL_GREEN: hue_w = signed'(HUE_W'(HUE_THIRD)) + rd_s - bd_s;
      default:   hue_w = signed'(HUE_W'(HUE_TWO_THIRDS)) + gd_s - rd_s;
    endcase
    if (hue_w < 0) hue_w = hue_w + signed'(HUE_W'(HLS_SCALE));
    if (hue_w > signed'(HUE_W'(HLS_SCALE))) hue_w = hue_w - signed'(HUE_W'(HLS_SCALE));
    if (ctl_last.grey) begin
      sat_nxt = '0;
      hue_nxt = HUE_GREY;
    end else begin
      sat_nxt = q_r[DIV_STAGES][DIV_SAT];
      hue_nxt = CHAN_W'(hue_w);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[NSTG-1]) begin
      lum_out_r <= ctl_last.lum;
      sat_out_r <= sat_nxt;
      hue_out_r <= hue_nxt;
    end
  end

  assign out_lightness  = lum_out_r;
  assign out_saturation = sat_out_r;
  assign out_hue        = hue_out_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_top_ge_bot: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[0] |-> (top_r >= bot_r))
    else $error("stage A max below min");

  a_hue_delta_range: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[NSTG-2] && !ctl_r[DIV_STAGES].grey) |->
      (q_r[DIV_STAGES][DIV_RD] <= HUE_SIXTH && q_r[DIV_STAGES][DIV_GD] <= HUE_SIXTH &&
       q_r[DIV_STAGES][DIV_BD] <= HUE_SIXTH))
    else $error("hue delta quotient out of range");

  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready && (&v_r)))
    else $error("input stalled with room in the pipeline");

endmodule

### test/tb_top.sv
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rth_pkg::*;

  localparam int unsigned LATENCY     = 7;
  localparam int unsigned RANDOM_PIX  = 1200;
  localparam int unsigned STALL_LIMIT = 2000;

  // one converted pixel
  typedef struct {
    logic [7:0] lum;
    logic [7:0] sat;
    logic [7:0] hue;
  } hls_t;

  // directed row: pixel, and whether the expected value is typed in
  typedef struct {
    logic [23:0] pix;
    bit          typed;
    hls_t        hls;
  } pix_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [23:0] in_packed_rgb;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_lightness;
  logic [7:0]  out_saturation;
  logic [7:0]  out_hue;

  rgb_to_hls_pixel_top dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_packed_rgb (in_packed_rgb),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_lightness (out_lightness),
    .out_saturation(out_saturation),
    .out_hue       (out_hue)
  );

  // Expected conversions, oldest first.
  hls_t hls_pending[$];
  int   mismatches;
  int   idle_cycles;
  bit   quiet_tail;   // no idling on either side near the end

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Rounded per-channel distance from the top channel, scaled so a full spread is one sixth of the hue scale.
  function automatic int hue_step(int top, int chan, int spread);
    return ((top - chan) * int'(HUE_SIXTH) + spread / 2) / spread;
  endfunction

  // Predict lightness, saturation and hue of one pixel.
  function automatic hls_t hls_of(logic [23:0] pix);
    hls_t res;
    int   r, g, b, top, bot, lum, sat, hue, spread, sum, rest, rd, gd, bd;
    r   = pix[7:0];
    g   = pix[15:8];
    b   = pix[23:16];
    top = r;
    bot = r;
    if (g > top) top = g;
    if (b > top) top = b;
    if (g < bot) bot = g;
    if (b < bot) bot = b;
    lum = ((top + bot) * 255 + 255) / 510;
    if (top == bot) begin
      sat = 0;
      hue = HUE_GREY;
    end else begin
      spread = top - bot;
      sum    = top + bot;
      if (lum <= 127) begin
        sat = (spread * 255 + sum / 2) / sum;
      end else begin
        rest = 510 - sum;
        sat  = (spread * 255 + rest / 2) / rest;
      end
      rd = hue_step(top, r, spread);
      gd = hue_step(top, g, spread);
      bd = hue_step(top, b, spread);
      // ties: red wins over green, green over blue
      if (r == top) hue = bd - gd;
      else if (g == top) hue = int'(HUE_THIRD) + rd - bd;
      else hue = int'(HUE_TWO_THIRDS) + gd - rd;
      if (hue < 0) hue += 255;
      if (hue > 255) hue -= 255;
    end
    if (sat > 255) sat = 255;
    res.lum = lum[7:0];
    res.sat = sat[7:0];
    res.hue = hue[7:0];
    return res;
  endfunction

  // Drive one pixel transaction, with an optional random gap in front.
  // Valid stays high after acceptance; a gap or the caller drops it.
  task automatic send_pixel(logic [23:0] pix, hls_t want_hls);
    int gap;
    if (!quiet_tail && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 17);
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_packed_rgb <= pix;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    hls_pending.push_back(want_hls);
  endtask

  // Random pixel, biased toward greys, ties and saturated corners.
  function automatic logic [23:0] random_pixel();
    logic [7:0] r, g, b;
    r = 8'($urandom);
    g = 8'($urandom);
    b = 8'($urandom);
    case ($urandom_range(0, 7))
      0: begin g = r; b = r; end
      1: g = r;
      2: b = g;
      3: begin r = 8'hFF; b = 8'h00; end
      4: begin r = 8'($urandom_range(250, 255)); g = 8'($urandom_range(250, 255)); end
      default: ;
    endcase
    return {b, g, r};
  endfunction

  // Receiver: random stalls, compare each result to the oldest prediction.
  initial begin
    hls_t want;
    int   stall;
    out_ready = 1'b0;
    mismatches = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!quiet_tail && $urandom_range(0, 9) == 0) begin
        out_ready <= 1'b0;
        stall = $urandom_range(1, 17);
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      if (out_valid && out_ready) begin
        if (hls_pending.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: result with nothing expected: L=%0d S=%0d H=%0d",
                     out_lightness, out_saturation, out_hue);
        end else begin
          want = hls_pending.pop_front();
          if (want.lum !== out_lightness || want.sat !== out_saturation ||
              want.hue !== out_hue) begin
            mismatches++;
            if (mismatches <= 10)
              $display("ERROR: expected L=%0d S=%0d H=%0d, got L=%0d S=%0d H=%0d",
                       want.lum, want.sat, want.hue,
                       out_lightness, out_saturation, out_hue);
          end
        end
      end
    end
  end

  // Watchdog: cycles without any transaction on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Stimulus.
  initial begin
    pix_row_t rows[$];
    hls_t     row_hls;
    int       drained;
    in_valid      = 1'b0;
    in_packed_rgb = '0;
    rst_n         = 1'b0;
    quiet_tail    = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed rows; typed expectations only where obvious.
    rows.push_back('{24'h000000, 1'b1, '{8'd0,   8'd0,   8'd170}}); // black
    rows.push_back('{24'hFFFFFF, 1'b1, '{8'd255, 8'd0,   8'd170}}); // white
    rows.push_back('{24'h808080, 1'b1, '{8'd128, 8'd0,   8'd170}}); // mid grey
    rows.push_back('{24'h0000FF, 1'b1, '{8'd128, 8'd255, 8'd0}});   // pure red
    rows.push_back('{24'h00FF00, 1'b1, '{8'd128, 8'd255, 8'd85}});  // pure green
    rows.push_back('{24'hFF0000, 1'b1, '{8'd128, 8'd255, 8'd170}}); // pure blue
    rows.push_back('{24'h00FFFF, 1'b0, '{8'd0, 8'd0, 8'd0}});  // red/green tie
    rows.push_back('{24'hFFFF00, 1'b0, '{8'd0, 8'd0, 8'd0}});  // green/blue tie
    rows.push_back('{24'hFF00FF, 1'b0, '{8'd0, 8'd0, 8'd0}});  // red/blue tie, negative hue
    rows.push_back('{24'hFF0080, 1'b0, '{8'd0, 8'd0, 8'd0}});  // blue top, red over green
    rows.push_back('{24'h000001, 1'b0, '{8'd0, 8'd0, 8'd0}});  // tiny spread, dark
    rows.push_back('{24'hFEFFFF, 1'b0, '{8'd0, 8'd0, 8'd0}});  // tiny spread, bright
    rows.push_back('{24'h7F8080, 1'b0, '{8'd0, 8'd0, 8'd0}});  // lightness right at half
    rows.push_back('{24'h010000, 1'b0, '{8'd0, 8'd0, 8'd0}});
    rows.push_back('{24'hAA55AA, 1'b0, '{8'd0, 8'd0, 8'd0}});
    rows.push_back('{24'h55AA55, 1'b0, '{8'd0, 8'd0, 8'd0}});
    foreach (rows[i]) begin
      if (rows[i].typed) row_hls = rows[i].hls;
      else row_hls = hls_of(rows[i].pix);
      send_pixel(rows[i].pix, row_hls);
    end
    in_valid <= 1'b0;

    // Hold off until everything has drained at least once.
    drained = 0;
    while (hls_pending.size() != 0 && drained < 100 * STALL_LIMIT) begin
      @(posedge clk);
      drained++;
    end

    for (int n = 0; n < RANDOM_PIX; n++) begin
      logic [23:0] pix;
      if (n == RANDOM_PIX - 150) quiet_tail = 1'b1;
      pix = random_pixel();
      send_pixel(pix, hls_of(pix));
    end
    in_valid <= 1'b0;

    while (hls_pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
    if (mismatches == 0 && hls_pending.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
